@@ rtl/jdq_pkg.sv @@
// Package for the joystick direction qualifier: direction codes, register
// indexes and the configuration bundle. No dependencies.
package jdq_pkg;

    localparam int unsigned AXIS_W    = 10;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned REPEAT_W  = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned S_DATA_W  = 56;
    localparam int unsigned M_DATA_W  = 8;

    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_UP    = 3'd1,
        DIR_DOWN  = 3'd2,
        DIR_LEFT  = 3'd3,
        DIR_RIGHT = 3'd4
    } dir_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUTER_LOW  = 3'd0,
        CFG_OUTER_HIGH = 3'd1,
        CFG_HOLD_LOW   = 3'd2,
        CFG_HOLD_HIGH  = 3'd3,
        CFG_REPEAT_MS  = 3'd4
    } cfg_idx_t;

    localparam logic [AXIS_W-1:0]   OUTER_LOW_RST  = 10'd257;
    localparam logic [AXIS_W-1:0]   OUTER_HIGH_RST = 10'd768;
    localparam logic [AXIS_W-1:0]   HOLD_LOW_RST   = 10'd386;
    localparam logic [AXIS_W-1:0]   HOLD_HIGH_RST  = 10'd641;
    localparam logic [REPEAT_W-1:0] REPEAT_MS_RST  = 16'd300;

    typedef struct packed {
        logic [AXIS_W-1:0]   outer_low;
        logic [AXIS_W-1:0]   outer_high;
        logic [AXIS_W-1:0]   hold_low;
        logic [AXIS_W-1:0]   hold_high;
        logic [REPEAT_W-1:0] repeat_ms;
    } cfg_t;

endpackage

@@ rtl/jdq_cfg_regs.sv @@
// Configuration register file for the joystick direction qualifier.
// Depends on jdq_pkg.
module jdq_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [jdq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jdq_pkg::CFG_DAT_W-1:0]  cfg_wdata,
    output jdq_pkg::cfg_t                  cfg
);
    import jdq_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.outer_low  <= OUTER_LOW_RST;
            cfg_reg.outer_high <= OUTER_HIGH_RST;
            cfg_reg.hold_low   <= HOLD_LOW_RST;
            cfg_reg.hold_high  <= HOLD_HIGH_RST;
            cfg_reg.repeat_ms  <= REPEAT_MS_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_OUTER_LOW:  cfg_reg.outer_low  <= cfg_wdata[AXIS_W-1:0];
                CFG_OUTER_HIGH: cfg_reg.outer_high <= cfg_wdata[AXIS_W-1:0];
                CFG_HOLD_LOW:   cfg_reg.hold_low   <= cfg_wdata[AXIS_W-1:0];
                CFG_HOLD_HIGH:  cfg_reg.hold_high  <= cfg_wdata[AXIS_W-1:0];
                CFG_REPEAT_MS:  cfg_reg.repeat_ms  <= cfg_wdata[REPEAT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/jdq_core.sv @@
// Direction classifier with hysteresis and repeat suppression; holds the
// last reported direction and its time. Depends on jdq_pkg.
module jdq_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  jdq_pkg::cfg_t                cfg,
    input  logic                         advance,
    input  logic [jdq_pkg::AXIS_W-1:0]   x_reading,
    input  logic [jdq_pkg::AXIS_W-1:0]   y_reading,
    input  logic [jdq_pkg::TIME_W-1:0]   now_ms,
    output jdq_pkg::dir_t                direction
);
    import jdq_pkg::*;

    dir_t              last_dir_reg;
    dir_t              last_dir_next;
    logic [TIME_W-1:0] last_time_reg;
    logic [TIME_W-1:0] last_time_next;
    dir_t              classified;
    logic [TIME_W-1:0] elapsed;
    logic              too_soon;

    always_comb begin
        if (x_reading < cfg.outer_low) begin
            classified = DIR_LEFT;
        end else if (x_reading > cfg.outer_high) begin
            classified = DIR_RIGHT;
        end else if (y_reading > cfg.outer_high) begin
            classified = DIR_UP;
        end else if (y_reading < cfg.outer_low) begin
            classified = DIR_DOWN;
        end else begin
            unique case (last_dir_reg)
                DIR_LEFT:  classified = (x_reading < cfg.hold_low)  ? DIR_LEFT  : DIR_NONE;
                DIR_RIGHT: classified = (x_reading > cfg.hold_high) ? DIR_RIGHT : DIR_NONE;
                DIR_UP:    classified = (y_reading > cfg.hold_high) ? DIR_UP    : DIR_NONE;
                DIR_DOWN:  classified = (y_reading < cfg.hold_low)  ? DIR_DOWN  : DIR_NONE;
                default:   classified = DIR_NONE;
            endcase
        end
    end

    assign elapsed  = now_ms - last_time_reg;
    assign too_soon = elapsed < {{(TIME_W-REPEAT_W){1'b0}}, cfg.repeat_ms};

    always_comb begin
        last_dir_next  = last_dir_reg;
        last_time_next = last_time_reg;
        direction      = DIR_NONE;
        if (classified == DIR_NONE) begin
            last_dir_next = DIR_NONE;
        end else if (!(classified == last_dir_reg && too_soon)) begin
            last_dir_next  = classified;
            last_time_next = now_ms;
            direction      = classified;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_dir_reg  <= DIR_NONE;
            last_time_reg <= '0;
        end else if (advance) begin
            last_dir_reg  <= last_dir_next;
            last_time_reg <= last_time_next;
        end
    end

endmodule

@@ rtl/joystick_direction_qualifier_top.sv @@
// Top level of the joystick direction qualifier: input beat register,
// classifier core and result register. Depends on jdq_pkg, jdq_cfg_regs, jdq_core.
//
//   channel | dir | payload (low bit up)                      | handshake
//   s_      | in  | x_reading[9:0] y_reading[19:10] now_ms    | tvalid/tready
//   m_      | out | direction[2:0]                            | tvalid/tready
//   cfg_    | in  | cfg_index selects, cfg_wdata value        | cfg_we
//
// One beat per cycle while m_tready is high; m_tvalid is the result stage's valid bit.
// The input register feeds the core and result register in one pass; the core's
// last-direction/last-time registers update as the beat moves to the result stage.
// A stalled m_ side holds the result; s_tready stays high while either stage can
// move. aresetn is synchronous, active low; it empties both stages and restores
// the register defaults.
module joystick_direction_qualifier_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // x_reading[9:0], y_reading[19:10], now_ms[51:20], zero[55:52]
    input  logic [jdq_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // direction[2:0], zero[7:3]
    output logic [jdq_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           cfg_we,
    input  logic [jdq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jdq_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
    import jdq_pkg::*;

    cfg_t              cfg;
    logic              in_valid_reg;
    logic [AXIS_W-1:0] in_x_reg;
    logic [AXIS_W-1:0] in_y_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic              out_valid_reg;
    dir_t              out_dir_reg;
    dir_t              core_dir;
    logic              out_free;
    logic              advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    jdq_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    jdq_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .advance   (advance),
        .x_reading (in_x_reg),
        .y_reading (in_y_reg),
        .now_ms    (in_now_reg),
        .direction (core_dir)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_x_reg   <= s_tdata[AXIS_W-1:0];
            in_y_reg   <= s_tdata[2*AXIS_W-1:AXIS_W];
            in_now_reg <= s_tdata[2*AXIS_W+TIME_W-1:2*AXIS_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_dir_reg <= core_dir;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-3){1'b0}}, out_dir_reg};

    a_dir_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= DIR_RIGHT))
        else $error("result direction code out of range");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_now_reg)
            && $stable(in_x_reg) && $stable(in_y_reg)))
        else $error("input stage lost a stalled beat");

    a_accept_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted beat not captured");

    a_advance_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("advanced beat missing from result stage");

endmodule

@@ sim/tb_joystick_direction_qualifier_top.sv @@
// Self-checking testbench for joystick_direction_qualifier_top: directed and randomized
// stick gestures checked beat by beat against an in-bench direction predictor.
// Depends on rtl/jdq_pkg.sv and rtl/joystick_direction_qualifier_top.sv.
`timescale 1ns / 1ps

module tb_joystick_direction_qualifier_top;

    import jdq_pkg::*;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          PIPE_SETTLE    = 4;
    localparam int          PAD_W          = S_DATA_W - 2 * AXIS_W - TIME_W;
    localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_IDX = CFG_IDX_W'(CFG_REPEAT_MS + 1);

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_wdata = '0;

    // predictor copy of the registers and the remembered direction and time
    logic [AXIS_W-1:0]     thr_outer_low  = OUTER_LOW_RST;
    logic [AXIS_W-1:0]     thr_outer_high = OUTER_HIGH_RST;
    logic [AXIS_W-1:0]     thr_hold_low   = HOLD_LOW_RST;
    logic [AXIS_W-1:0]     thr_hold_high  = HOLD_HIGH_RST;
    logic [REPEAT_W-1:0]   repeat_gap_ms  = REPEAT_MS_RST;
    dir_t                  held_dir       = DIR_NONE;
    logic [TIME_W-1:0]     held_time      = '0;

    dir_t                  dir_expected[$];
    logic [TIME_W-1:0]     clock_ms       = '0;
    bit                    quiet          = 1'b0;
    int                    samples_sent   = 0;
    int                    errors         = 0;
    int                    stall_cycles   = 0;

    joystick_direction_qualifier_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic dir_t qualify(input logic [AXIS_W-1:0] x, input logic [AXIS_W-1:0] y,
                                     input logic [TIME_W-1:0] now);
        dir_t              d;
        logic [TIME_W-1:0] elapsed;
        if (x < thr_outer_low) begin
            d = DIR_LEFT;
        end else if (x > thr_outer_high) begin
            d = DIR_RIGHT;
        end else if (y > thr_outer_high) begin
            d = DIR_UP;
        end else if (y < thr_outer_low) begin
            d = DIR_DOWN;
        end else begin
            d = DIR_NONE;
            case (held_dir)
                DIR_LEFT:  if (x < thr_hold_low)  d = DIR_LEFT;
                DIR_RIGHT: if (x > thr_hold_high) d = DIR_RIGHT;
                DIR_UP:    if (y > thr_hold_high) d = DIR_UP;
                DIR_DOWN:  if (y < thr_hold_low)  d = DIR_DOWN;
                default: ;
            endcase
        end
        if (d == DIR_NONE) begin
            held_dir = DIR_NONE;
            return DIR_NONE;
        end
        elapsed = now - held_time;
        if (d == held_dir && elapsed < repeat_gap_ms)
            return DIR_NONE;
        held_dir  = d;
        held_time = now;
        return d;
    endfunction

    function automatic logic [TIME_W-1:0] next_time();
        case ($urandom_range(9))
            0:       clock_ms = $urandom;
            1, 2:    clock_ms = held_time + repeat_gap_ms - 1 + $urandom_range(2);
            default: clock_ms = clock_ms + $urandom_range(repeat_gap_ms / 3 + 2);
        endcase
        return clock_ms;
    endfunction

    function automatic logic [AXIS_W-1:0] centre_level();
        return AXIS_W'($urandom_range(thr_hold_high, thr_hold_low));
    endfunction

    function automatic logic [AXIS_W-1:0] side_level(input bit high);
        logic [AXIS_W-1:0] v;
        int                k;
        case ($urandom_range(3))
            0: v = high ? AXIS_W'($urandom_range(1023, thr_outer_high))
                        : AXIS_W'($urandom_range(thr_outer_low, 0));
            1: v = high ? AXIS_W'($urandom_range(thr_outer_high, thr_hold_high))
                        : AXIS_W'($urandom_range(thr_hold_low, thr_outer_low));
            default: begin
                k = $urandom_range(1) ? (high ? thr_outer_high : thr_outer_low)
                                      : (high ? thr_hold_high : thr_hold_low);
                k = k + int'($urandom_range(2)) - 1;
                v = (k < 0) ? '0 : (k > 1023) ? '1 : AXIS_W'(k);
            end
        endcase
        return v;
    endfunction

    always @(negedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= 8);
    end

    always @(posedge aclk) begin
        dir_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (dir_expected.size() == 0) begin
                $display("%0t: unexpected result beat, expected nothing, actual %0d",
                         $time, m_tdata);
                errors++;
            end else begin
                want = dir_expected.pop_front();
                if (m_tdata !== {{(M_DATA_W-3){1'b0}}, want}) begin
                    $display("%0t: direction mismatch, expected %s (%0d), actual %0d",
                             $time, want.name(), want, m_tdata);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_sample(input logic [AXIS_W-1:0] x, input logic [AXIS_W-1:0] y,
                               input logic [TIME_W-1:0] now);
        while (!quiet && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, now, y, x};
        do @(posedge aclk); while (!s_tready);
        dir_expected.push_back(qualify(x, y, now));
        samples_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (dir_expected.size() != 0) @(negedge aclk);
        repeat (PIPE_SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_OUTER_LOW:  thr_outer_low  = val[AXIS_W-1:0];
            CFG_OUTER_HIGH: thr_outer_high = val[AXIS_W-1:0];
            CFG_HOLD_LOW:   thr_hold_low   = val[AXIS_W-1:0];
            CFG_HOLD_HIGH:  thr_hold_high  = val[AXIS_W-1:0];
            CFG_REPEAT_MS:  repeat_gap_ms  = val[REPEAT_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // upper bits of the 10-bit registers carry junk that must be dropped
    task automatic set_thresholds(input logic [AXIS_W-1:0] ol, input logic [AXIS_W-1:0] oh,
                                  input logic [AXIS_W-1:0] hl, input logic [AXIS_W-1:0] hh,
                                  input logic [REPEAT_W-1:0] rep);
        wait_idle();
        write_reg(CFG_OUTER_LOW,  {6'($urandom), ol});
        write_reg(CFG_OUTER_HIGH, {6'($urandom), oh});
        write_reg(CFG_HOLD_LOW,   {6'($urandom), hl});
        write_reg(CFG_HOLD_HIGH,  {6'($urandom), hh});
        write_reg(CFG_REPEAT_MS,  rep);
    endtask

    task automatic set_random_window(input logic [REPEAT_W-1:0] rep);
        logic [AXIS_W-1:0] ol, oh, hl, hh;
        ol = AXIS_W'($urandom_range(50, 400));
        hl = AXIS_W'($urandom_range(ol, 480));
        hh = AXIS_W'($urandom_range(540, 980));
        oh = AXIS_W'($urandom_range(hh, 1000));
        set_thresholds(ol, oh, hl, hh, rep);
    endtask

    task automatic gesture();
        dir_t              d;
        logic [AXIS_W-1:0] a, c;
        d = dir_t'($urandom_range(DIR_RIGHT, DIR_UP));
        repeat ($urandom_range(1, 8)) begin
            a = side_level(d == DIR_RIGHT || d == DIR_UP);
            c = ($urandom_range(3) == 0) ? AXIS_W'($urandom_range(1023)) : centre_level();
            if (d == DIR_LEFT || d == DIR_RIGHT)
                send_sample(a, c, next_time());
            else
                send_sample(c, a, next_time());
        end
        repeat ($urandom_range(2)) send_sample(centre_level(), centre_level(), next_time());
    endtask

    task automatic random_phase(input int count);
        int stop;
        stop = samples_sent + count;
        while (samples_sent < stop) begin
            if ($urandom_range(99) < 80)
                gesture();
            else
                send_sample(AXIS_W'($urandom_range(1023)), AXIS_W'($urandom_range(1023)),
                            next_time());
            if ($urandom_range(199) == 0)
                wait_idle();
        end
    endtask

    task automatic test_directed();
        send_sample(10'd512,  10'd512,  32'd1000);
        send_sample(10'd0,    10'd512,  32'd1000);
        send_sample(10'd300,  10'd512,  32'd1100);
        send_sample(10'd385,  10'd512,  32'd1300);
        send_sample(10'd386,  10'd512,  32'd1301);
        send_sample(10'd1023, 10'd1023, 32'd1302);
        send_sample(10'd768,  10'd512,  32'd1303);
        send_sample(10'd769,  10'd0,    32'd1602);
        send_sample(10'd256,  10'd1023, 32'd1603);
        send_sample(10'd512,  10'd1023, 32'd1604);
        send_sample(10'd512,  10'd642,  32'd1700);
        send_sample(10'd512,  10'd641,  32'd1701);
        send_sample(10'd512,  10'd0,    32'd1702);
        send_sample(10'd512,  10'd385,  32'd2100);
        send_sample(10'd512,  10'd257,  32'd2101);
        send_sample(10'd512,  10'd386,  32'd2102);
        send_sample(10'd1023, 10'd512,  32'hFFFF_FF00);
        send_sample(10'd700,  10'd512,  32'h0000_002B);
        send_sample(10'd700,  10'd512,  32'h0000_002C);
        send_sample(10'd0,    10'd0,    32'hFFFF_FFFF);
        send_sample(10'd0,    10'd1023, 32'd0);
    endtask

    task automatic test_register_extremes();
        set_thresholds('0, '1, '0, '1, '0);
        send_sample(10'd0,    10'd0,    32'd10);
        send_sample(10'd1023, 10'd1023, 32'd11);
        send_sample(10'd512,  10'd512,  32'd12);
        send_sample(10'd0,    10'd1023, 32'd12);
        set_thresholds('1, '0, '1, '0, '1);
        send_sample(10'd1023, 10'd1023, 32'd20);
        send_sample(10'd1023, 10'd512,  32'd21);
        send_sample(10'd0,    10'd512,  32'd22);
        send_sample(10'd1023, 10'd0,    32'd65555);
        send_sample(10'd1023, 10'd0,    32'd65556);
    endtask

    task automatic test_spare_indexes();
        set_thresholds(OUTER_LOW_RST, OUTER_HIGH_RST, HOLD_LOW_RST, HOLD_HIGH_RST,
                       REPEAT_MS_RST);
        for (int i = FIRST_SPARE_IDX; i < 2 ** CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), CFG_DAT_W'($urandom));
        repeat (3) gesture();
    endtask

    task automatic test_random_traffic();
        set_thresholds(OUTER_LOW_RST, OUTER_HIGH_RST, HOLD_LOW_RST, HOLD_HIGH_RST,
                       REPEAT_MS_RST);
        random_phase(175);
        wait_idle();
        random_phase(175);
        set_random_window(REPEAT_W'($urandom_range(2000)));
        quiet = 1'b1;
        random_phase(350);
        quiet = 1'b0;
        set_thresholds('0, '1, AXIS_W'($urandom), AXIS_W'($urandom), '0);
        random_phase(250);
        set_thresholds('1, '0, '0, '1, '1);
        random_phase(250);
        set_random_window('1);
        random_phase(300);
        set_thresholds(AXIS_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom),
                       AXIS_W'($urandom), REPEAT_W'($urandom));
        random_phase(320);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_register_extremes();
        test_spare_indexes();
        test_random_traffic();
        wait_idle();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ files.f @@
rtl/jdq_pkg.sv
rtl/jdq_cfg_regs.sv
rtl/jdq_core.sv
rtl/joystick_direction_qualifier_top.sv
sim/tb_joystick_direction_qualifier_top.sv
